@@ sv/tda_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tda_pkg
// Shared codes and types for the table-driven automaton: request kinds and
// the sequencer state encoding.
// ----------------------------------------------------------------------------
package tda_pkg;

  // Request kinds
  localparam logic [1:0] KIND_APPEND  = 2'd0;
  localparam logic [1:0] KIND_SET     = 2'd1;
  localparam logic [1:0] KIND_ADVANCE = 2'd2;

  // Sequencer states, one-hot
  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_TRUE1 = 6'b000010,
    S_SYM   = 6'b000100,
    S_TRUE2 = 6'b001000,
    S_MASK  = 6'b010000,
    S_DONE  = 6'b100000
  } fsm_state_t;

endpackage

@@ sv/tda_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tda_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module tda_ram #(
  parameter int WIDTH = 21,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

@@ sv/table_driven_automaton.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// table_driven_automaton
// Programmable automaton: transition table held in RAM, scanned one entry
// per cycle to follow always-true edges, symbol edges and build the mask.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one request: append a table
//   entry, set the current state, or advance on a symbol. Output channel
//   (out_valid / out_stall) returns one result per request: the state after
//   it, the mask of conditions leaving that state and status flags.
//   One request is worked on at a time; in_stall is high while busy.
//   Every pass over the table reads one entry per cycle from the single read
//   port of the table RAM; a chain or symbol pass ends at its first hit.
//   Append, set-state and unused kind: one pass (mask).
//   Advance: (T1+1) passes for the first true-edge chain, one for the symbol,
//   (T2+1) for the second chain and one for the mask, where T1/T2 are the
//   true edges followed (each at most TABLE_DEPTH); no symbol match skips
//   the second chain.
//   The result sits in an output register: the next request is taken while
//   a result waits; a finished request holds in its last state until the
//   output register frees up.
//   Reset empties the table (entry count zero) and sets the state to zero.
// ----------------------------------------------------------------------------
module table_driven_automaton #(
  parameter int TABLE_DEPTH  = 64,
  parameter int STATE_IDS    = 256,
  parameter int SYMBOL_COUNT = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  // request channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        kind,
  input  logic [$clog2(STATE_IDS)-1:0]      entry_origin,
  input  logic [$clog2(SYMBOL_COUNT)-1:0]   entry_condition,
  input  logic [$clog2(STATE_IDS)-1:0]      entry_dest,
  input  logic [$clog2(STATE_IDS)-1:0]      new_state,
  input  logic [$clog2(SYMBOL_COUNT)-1:0]   event_symbol,
  // result channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [$clog2(STATE_IDS)-1:0]      current_state,
  output logic [SYMBOL_COUNT-1:0]           possible_mask,
  output logic                              table_full,
  output logic                              true_loop,
  output logic [$clog2(TABLE_DEPTH+1)-1:0]  entry_count
);

  localparam int AW   = $clog2(TABLE_DEPTH);
  localparam int CW   = $clog2(TABLE_DEPTH + 1);
  localparam int SIDW = $clog2(STATE_IDS);
  localparam int SYW  = $clog2(SYMBOL_COUNT);
  localparam int MW   = SYMBOL_COUNT;
  localparam int DW   = 2 * SIDW + SYW;
  localparam logic [SIDW-1:0] SINK  = SIDW'(STATE_IDS - 1);
  localparam logic [CW-1:0]   DEPTH = CW'(TABLE_DEPTH);

  tda_pkg::fsm_state_t state, state_next;

  // control registers
  logic [CW-1:0]   count_held;
  logic [SIDW-1:0] present_state;
  logic [CW-1:0]   idx;
  logic            pend;

  // working registers
  logic [SIDW-1:0] s;
  logic [SYW-1:0]  sym;
  logic [CW-1:0]   steps;
  logic            loop_flag;
  logic            full_flag;
  logic [MW-1:0]   mask;

  // table RAM: {origin, condition, dest}
  logic            ram_we;
  logic [DW-1:0]   ram_wdata;
  logic [DW-1:0]   rdata;
  logic [SIDW-1:0] rd_origin;
  logic [SYW-1:0]  rd_cond;
  logic [SIDW-1:0] rd_dest;

  logic in_accept;
  logic out_load;
  logic more;
  logic exhausted;
  logic match_org;
  logic match_true;
  logic match_sym;
  logic chain_cut;
  logic scan_reset;
  logic scanning;

  assign in_stall  = (state != tda_pkg::S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_load  = (state == tda_pkg::S_DONE) && (!out_valid || !out_stall);

  assign ram_we    = in_accept && (kind == tda_pkg::KIND_APPEND) && (count_held < DEPTH);
  assign ram_wdata = {entry_origin, entry_condition, entry_dest};

  tda_ram #(
    .WIDTH (DW),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count_held[AW-1:0]),
    .wdata (ram_wdata),
    .raddr (idx[AW-1:0]),
    .rdata (rdata)
  );

  // Compare the entry read last cycle
  assign rd_origin  = rdata[DW-1 -: SIDW];
  assign rd_cond    = rdata[SIDW+SYW-1 -: SYW];
  assign rd_dest    = rdata[SIDW-1:0];
  assign match_org  = pend && (rd_origin == s);
  assign match_true = match_org && (rd_cond == '0);
  assign match_sym  = match_org && (rd_cond == sym);
  assign chain_cut  = match_true && (steps >= DEPTH);
  assign more       = (idx < count_held);
  assign exhausted  = !pend && !more;

  assign scanning = (state == tda_pkg::S_TRUE1) || (state == tda_pkg::S_SYM) ||
                    (state == tda_pkg::S_TRUE2) || (state == tda_pkg::S_MASK);

  // Restart the scan index on a hit (chain step or phase change) or at the end
  always_comb begin
    unique case (state)
      tda_pkg::S_TRUE1, tda_pkg::S_TRUE2: scan_reset = match_true || exhausted;
      tda_pkg::S_SYM:                     scan_reset = match_sym || exhausted;
      tda_pkg::S_MASK:                    scan_reset = exhausted;
      default:                            scan_reset = 1'b1;
    endcase
  end

  // Sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      tda_pkg::S_IDLE: begin
        if (in_accept) begin
          state_next = (kind == tda_pkg::KIND_ADVANCE) ? tda_pkg::S_TRUE1 : tda_pkg::S_MASK;
        end
      end
      tda_pkg::S_TRUE1: begin
        if (chain_cut || exhausted) state_next = tda_pkg::S_SYM;
      end
      tda_pkg::S_SYM: begin
        if (match_sym) state_next = tda_pkg::S_TRUE2;
        else if (exhausted) state_next = tda_pkg::S_MASK;
      end
      tda_pkg::S_TRUE2: begin
        if (chain_cut || exhausted) state_next = tda_pkg::S_MASK;
      end
      tda_pkg::S_MASK: begin
        if (exhausted) state_next = tda_pkg::S_DONE;
      end
      tda_pkg::S_DONE: begin
        if (out_load) state_next = tda_pkg::S_IDLE;
      end
      default: state_next = tda_pkg::S_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= tda_pkg::S_IDLE;
      count_held    <= '0;
      present_state <= '0;
      idx           <= '0;
      pend          <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      state <= state_next;
      if (ram_we) count_held <= count_held + CW'(1);
      if (out_load) present_state <= s;
      // scan address: one read issued per cycle
      if (!scanning || scan_reset) begin
        idx  <= '0;
        pend <= 1'b0;
      end else if (more) begin
        idx  <= idx + CW'(1);
        pend <= 1'b1;
      end else begin
        pend <= 1'b0;
      end
      if (out_load) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  // Working registers and result register
  always_ff @(posedge clk) begin
    unique case (state)
      tda_pkg::S_IDLE: begin
        if (in_accept) begin
          s         <= (kind == tda_pkg::KIND_SET) ? new_state : present_state;
          sym       <= event_symbol;
          steps     <= '0;
          loop_flag <= 1'b0;
          full_flag <= (kind == tda_pkg::KIND_APPEND) && (count_held >= DEPTH);
          mask      <= '0;
        end
      end
      tda_pkg::S_TRUE1, tda_pkg::S_TRUE2: begin
        if (chain_cut) begin
          loop_flag <= 1'b1;
        end else if (match_true) begin
          s     <= rd_dest;
          steps <= steps + CW'(1);
        end
      end
      tda_pkg::S_SYM: begin
        if (match_sym) begin
          s     <= rd_dest;
          steps <= '0;
        end else if (exhausted) begin
          s <= SINK;
        end
      end
      tda_pkg::S_MASK: begin
        if (match_org) mask <= mask | (MW'(1) << rd_cond);
      end
      tda_pkg::S_DONE: begin
        if (out_load) begin
          current_state <= s;
          possible_mask <= mask;
          table_full    <= full_flag;
          true_loop     <= loop_flag;
          entry_count   <= count_held;
        end
      end
      default: ;
    endcase
  end

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count_held <= DEPTH)
    else $error("entry count beyond table depth");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && table_full |-> entry_count == DEPTH)
    else $error("dropped append reported with table not full");

  a_read_in_range: assert property (@(posedge clk) disable iff (rst)
    pend |-> (idx != '0) && (idx <= count_held))
    else $error("table read outside held entries");

  a_steps_bound: assert property (@(posedge clk) disable iff (rst)
    (state == tda_pkg::S_TRUE1 || state == tda_pkg::S_TRUE2) |-> steps <= DEPTH)
    else $error("true-edge chain ran past the step limit");

endmodule
